### src/arsh_pkg.sv
// ---------------------------------------------------------------------------
// arsh_pkg - shared types and constants for the audit record sieve hash
// Byte codes, register indexes, configuration widths and parse phases.
// ---------------------------------------------------------------------------
`default_nettype none

package arsh_pkg;

    localparam int unsigned MAX_FIELDS_DEF = 25;
    localparam int unsigned IDX_W          = 6;
    localparam int unsigned HASH_W         = 64;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned TYPE_W         = 16;

    localparam int unsigned SYSCALL_MASK_W = 25;
    localparam int unsigned CWD_MASK_W     = 1;
    localparam int unsigned PATH_MASK_W    = 8;

    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 25;

    localparam logic [HASH_W-1:0] SEED_HASH  = 64'd5381;
    // seed already multiplied by 33
    localparam logic [HASH_W-1:0] SEED_MIXED = (SEED_HASH << 5) + SEED_HASH;

    localparam logic [BYTE_W-1:0] BYTE_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_EQUALS = 8'h3D;

    localparam logic [TYPE_W-1:0]         SYSCALL_TYPE_RST = 16'd1300;
    localparam logic [TYPE_W-1:0]         CWD_TYPE_RST     = 16'd1307;
    localparam logic [TYPE_W-1:0]         PATH_TYPE_RST    = 16'd1302;
    localparam logic [SYSCALL_MASK_W-1:0] SYSCALL_MASK_RST = 25'd13038958;
    localparam logic [CWD_MASK_W-1:0]     CWD_MASK_RST     = 1'b1;
    localparam logic [PATH_MASK_W-1:0]    PATH_MASK_RST    = 8'd118;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYSCALL_TYPE = 3'd0,
        CFG_CWD_TYPE     = 3'd1,
        CFG_PATH_TYPE    = 3'd2,
        CFG_SYSCALL_MASK = 3'd3,
        CFG_CWD_MASK     = 3'd4,
        CFG_PATH_MASK    = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_SPACES = 2'd1,
        PH_NAME   = 2'd2,
        PH_VALUE  = 2'd3
    } parse_phase_t;

endpackage

`default_nettype wire

### src/audit_record_sieve_hash_top.sv
// ---------------------------------------------------------------------------
// audit_record_sieve_hash_top - sieved multiply-by-33 xor hash of audit records
// Streams a record one byte per request and returns one 64-bit hash per record.
// ---------------------------------------------------------------------------
// The block takes one byte per cycle on the input channel: every request is
// folded into the record state in the cycle it is accepted, with one shift-and-
// add (hash*33) and one xor between the state registers, so a byte may follow
// in the very next cycle. The request that carries last_byte produces one
// hash on the output channel; no other request produces anything. Results
// sit in a two-entry output queue, so the input keeps accepting while one
// hash waits to be taken; the input stalls only while both entries are held.
// The last byte's hash is registered into the queue. The parser skips
// the record prefix up to the first space, hashes field names, and hashes a
// field's value only when the field's bit is set in the mask that the record
// type selected. The six registers on the configuration port are always
// ready; write them only while no record is in flight.
`default_nettype none

module audit_record_sieve_hash_top
    import arsh_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [BYTE_W-1:0]     char_byte,
    input  wire logic [TYPE_W-1:0]     record_type,
    input  wire logic                  first_byte,
    input  wire logic                  last_byte,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [HASH_W-1:0]          record_hash,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // only fields below both the parameter and the widest mask can be kept
    localparam int unsigned MASK_W = (MAX_FIELDS < SYSCALL_MASK_W) ? MAX_FIELDS
                                                                   : SYSCALL_MASK_W;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MASK_W);
    localparam logic [IDX_W-1:0] IDX_MAX   = {IDX_W{1'b1}};

    // configuration registers
    logic [TYPE_W-1:0]         syscall_type_reg;
    logic [TYPE_W-1:0]         cwd_type_reg;
    logic [TYPE_W-1:0]         path_type_reg;
    logic [SYSCALL_MASK_W-1:0] syscall_mask_reg;
    logic [CWD_MASK_W-1:0]     cwd_mask_reg;
    logic [PATH_MASK_W-1:0]    path_mask_reg;

    // record state
    logic [HASH_W-1:0]         hash_reg,  hash_next;
    parse_phase_t              phase_reg, phase_next;
    logic [IDX_W-1:0]          idx_reg,   idx_next;
    logic [MASK_W-1:0]         mask_reg,  mask_next;
    logic                      keep_reg,  keep_next;

    // output queue
    logic [HASH_W-1:0]         queue_reg [2];
    logic                      wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                count_reg,  count_next;

    // effective state for this request, after a first byte restarts it
    logic [HASH_W-1:0]         cur_hash;
    parse_phase_t              cur_phase;
    logic [IDX_W-1:0]          cur_idx;
    logic [MASK_W-1:0]         cur_mask;
    logic                      cur_keep;
    logic [SYSCALL_MASK_W-1:0] sel_mask;
    logic [MASK_W-1:0]         mask_shift;
    logic [HASH_W-1:0]         folded;
    logic [HASH_W-1:0]         new_hash;
    parse_phase_t              new_phase;
    logic [IDX_W-1:0]          new_idx;
    logic                      new_keep;
    logic                      is_space, is_equals, name_step;
    logic                      in_acc, push, pop;

    assign in_acc    = in_valid && in_ready;
    assign push      = in_acc && last_byte;
    assign pop       = out_valid && out_ready;
    assign in_ready  = !count_reg[1];
    assign out_valid = (count_reg != 2'd0);
    assign cfg_ready = 1'b1;
    assign record_hash = queue_reg[rd_ptr_reg];

    assign is_space  = (char_byte == BYTE_SPACE);
    assign is_equals = (char_byte == BYTE_EQUALS);

    // configuration writes; unknown indexes fall through untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syscall_type_reg <= SYSCALL_TYPE_RST;
            cwd_type_reg     <= CWD_TYPE_RST;
            path_type_reg    <= PATH_TYPE_RST;
            syscall_mask_reg <= SYSCALL_MASK_RST;
            cwd_mask_reg     <= CWD_MASK_RST;
            path_mask_reg    <= PATH_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SYSCALL_TYPE: syscall_type_reg <= cfg_data[TYPE_W-1:0];
                CFG_CWD_TYPE:     cwd_type_reg     <= cfg_data[TYPE_W-1:0];
                CFG_PATH_TYPE:    path_type_reg    <= cfg_data[TYPE_W-1:0];
                CFG_SYSCALL_MASK: syscall_mask_reg <= cfg_data[SYSCALL_MASK_W-1:0];
                CFG_CWD_MASK:     cwd_mask_reg     <= cfg_data[CWD_MASK_W-1:0];
                CFG_PATH_MASK:    path_mask_reg    <= cfg_data[PATH_MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    // pick the field mask; syscall wins over cwd, cwd over path
    always_comb
    begin
        if (record_type == syscall_type_reg)
            sel_mask = syscall_mask_reg;
        else if (record_type == cwd_type_reg)
            sel_mask = SYSCALL_MASK_W'(cwd_mask_reg);
        else if (record_type == path_type_reg)
            sel_mask = SYSCALL_MASK_W'(path_mask_reg);
        else
            sel_mask = '0;
    end

    // a first byte restarts the record before the byte itself is parsed
    always_comb
    begin
        if (first_byte)
        begin
            cur_hash  = SEED_MIXED ^ HASH_W'(record_type);
            cur_phase = PH_PREFIX;
            cur_idx   = '0;
            cur_mask  = sel_mask[MASK_W-1:0];
            cur_keep  = 1'b0;
        end
        else
        begin
            cur_hash  = hash_reg;
            cur_phase = phase_reg;
            cur_idx   = idx_reg;
            cur_mask  = mask_reg;
            cur_keep  = keep_reg;
        end
    end

    // parse phase: next state only
    always_comb
    begin
        new_phase = cur_phase;
        case (cur_phase)
            PH_PREFIX:
            begin
                if (is_space)
                    new_phase = PH_SPACES;
            end
            PH_SPACES:
            begin
                if (!is_space)
                    new_phase = is_equals ? PH_VALUE : PH_NAME;
            end
            PH_NAME:
            begin
                if (is_equals)
                    new_phase = PH_VALUE;
            end
            PH_VALUE:
            begin
                if (is_space)
                    new_phase = PH_NAME;
            end
            default:
            begin
                new_phase = PH_PREFIX;
            end
        endcase
    end

    // hash, field index and keep flag for this byte
    always_comb
    begin
        // the first non-space after the prefix is already a name byte
        name_step  = (cur_phase == PH_NAME) || ((cur_phase == PH_SPACES) && !is_space);
        folded     = ((cur_hash << 5) + cur_hash) ^ {{(HASH_W-BYTE_W){char_byte[BYTE_W-1]}},
                                                    char_byte};
        mask_shift = cur_mask >> cur_idx;
        new_hash   = cur_hash;
        new_idx    = cur_idx;
        new_keep   = cur_keep;
        if (name_step)
        begin
            if (is_equals)
            begin
                new_keep = (cur_idx < IDX_LIMIT) && mask_shift[0];
                if (cur_idx != IDX_MAX)
                    new_idx = cur_idx + 1'b1;
            end
            else
            begin
                new_hash = folded;
            end
        end
        else if ((cur_phase == PH_VALUE) && !is_space && cur_keep)
        begin
            new_hash = folded;
        end
    end

    // advance the record state, or clear it when the last byte is accepted
    always_comb
    begin
        hash_next  = hash_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        mask_next  = mask_reg;
        keep_next  = keep_reg;
        if (in_acc)
        begin
            if (last_byte)
            begin
                hash_next  = '0;
                phase_next = PH_PREFIX;
                idx_next   = '0;
                mask_next  = '0;
                keep_next  = 1'b0;
            end
            else
            begin
                hash_next  = new_hash;
                phase_next = new_phase;
                idx_next   = new_idx;
                mask_next  = cur_mask;
                keep_next  = new_keep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            phase_reg <= PH_PREFIX;
            idx_reg   <= '0;
            mask_reg  <= '0;
            keep_reg  <= 1'b0;
        end
        else
        begin
            hash_reg  <= hash_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            mask_reg  <= mask_next;
            keep_reg  <= keep_next;
        end
    end

    // output queue: hold up to two finished hashes
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= new_hash;
    end

endmodule

`default_nettype wire

### src/arsh_checker.sv
// ---------------------------------------------------------------------------
// arsh_checker - port-level checks for the audit record sieve hash
// Watches the top level's channels and flags results lost or invented.
// ---------------------------------------------------------------------------
`default_nettype none

module arsh_checker
    import arsh_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  last_byte,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [HASH_W-1:0]     record_hash
);

    // a stalled result must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(record_hash))
        else $error("result dropped or changed while stalled");

    // the input stalls only while results are pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // a last byte into an empty output shows a result next cycle
    a_result_made: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_byte && !out_valid |=> out_valid)
        else $error("result lost for a last byte");

    // a byte that ends no record invents no result
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last_byte && !out_valid |=> !out_valid)
        else $error("result without a last byte");

endmodule

bind audit_record_sieve_hash_top arsh_checker u_arsh_checker (.*);

`default_nettype wire

### tb/arsh_hash_checker.sv
// ---------------------------------------------------------------------------
// arsh_hash_checker - prediction and comparison for the audit record hash
// Watches the byte, hash and register channels of the block, keeps its own
// copy of the parser state and registers, and compares every hash in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module arsh_hash_checker
    import arsh_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [BYTE_W-1:0]     char_byte,
    input  wire logic [TYPE_W-1:0]     record_type,
    input  wire logic                  first_byte,
    input  wire logic                  last_byte,

    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [HASH_W-1:0]     record_hash,

    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    output int                         fail_count,
    output int                         pending_hashes,
    output int                         hashes_checked
);

    // register copies
    logic [TYPE_W-1:0]         sys_code;
    logic [TYPE_W-1:0]         cwd_code;
    logic [TYPE_W-1:0]         path_code;
    logic [SYSCALL_MASK_W-1:0] sys_mask;
    logic [CWD_MASK_W-1:0]     cwd_mask;
    logic [PATH_MASK_W-1:0]    path_mask;

    // record state
    logic [HASH_W-1:0]         hash_acc;
    parse_phase_t              phase;
    logic [IDX_W-1:0]          field_no;
    logic [SYSCALL_MASK_W-1:0] sel_mask;
    logic                      keep;

    logic [HASH_W-1:0]         expected_hashes[$];
    logic                      emit;
    logic [HASH_W-1:0]         hash_now;
    logic [HASH_W-1:0]         want;

    // hash*33 xor the byte taken as a signed char
    function automatic logic [HASH_W-1:0] times33_xor(input logic [HASH_W-1:0] h,
                                                      input logic [BYTE_W-1:0] b);
        return ((h << 5) + h) ^ {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    task automatic clear_record_state();
        hash_acc = '0;
        phase    = PH_PREFIX;
        field_no = '0;
        sel_mask = '0;
        keep     = 1'b0;
    endtask

    task automatic fold_audit_byte(input logic [BYTE_W-1:0] b, input logic [TYPE_W-1:0] t,
                                   input logic first, input logic last,
                                   output logic done, output logic [HASH_W-1:0] hash_out);
        logic [IDX_W-1:0] idx;
        if (first)
        begin
            hash_acc = SEED_MIXED ^ {{(HASH_W-TYPE_W){1'b0}}, t};
            phase    = PH_PREFIX;
            field_no = '0;
            keep     = 1'b0;
            // syscall wins over cwd, cwd over path
            if (t == sys_code)
                sel_mask = sys_mask;
            else if (t == cwd_code)
                sel_mask = {{(SYSCALL_MASK_W-CWD_MASK_W){1'b0}}, cwd_mask};
            else if (t == path_code)
                sel_mask = {{(SYSCALL_MASK_W-PATH_MASK_W){1'b0}}, path_mask};
            else
                sel_mask = '0;
        end
        case (phase)
            PH_PREFIX:
            begin
                if (b == BYTE_SPACE)
                    phase = PH_SPACES;
            end
            PH_VALUE:
            begin
                if (b == BYTE_SPACE)
                    phase = PH_NAME;
                else if (keep)
                    hash_acc = times33_xor(hash_acc, b);
            end
            default:
            begin
                // extra spaces after the prefix are skipped; anything else opens a name
                if (!(phase == PH_SPACES && b == BYTE_SPACE))
                begin
                    phase = PH_NAME;
                    if (b == BYTE_EQUALS)
                    begin
                        idx = field_no;
                        if (idx < MAX_FIELDS_DEF && idx < SYSCALL_MASK_W)
                            keep = sel_mask[idx];
                        else
                            keep = 1'b0;
                        if (idx != {IDX_W{1'b1}})
                            field_no = idx + 1'b1;
                        phase = PH_VALUE;
                    end
                    else
                    begin
                        hash_acc = times33_xor(hash_acc, b);
                    end
                end
            end
        endcase
        done     = last;
        hash_out = hash_acc;
        if (last)
            clear_record_state();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_code  = SYSCALL_TYPE_RST;
            cwd_code  = CWD_TYPE_RST;
            path_code = PATH_TYPE_RST;
            sys_mask  = SYSCALL_MASK_RST;
            cwd_mask  = CWD_MASK_RST;
            path_mask = PATH_MASK_RST;
            clear_record_state();
            expected_hashes.delete();
            fail_count     = 0;
            pending_hashes = 0;
            hashes_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SYSCALL_TYPE: sys_code  = cfg_data[TYPE_W-1:0];
                    CFG_CWD_TYPE:     cwd_code  = cfg_data[TYPE_W-1:0];
                    CFG_PATH_TYPE:    path_code = cfg_data[TYPE_W-1:0];
                    CFG_SYSCALL_MASK: sys_mask  = cfg_data[SYSCALL_MASK_W-1:0];
                    CFG_CWD_MASK:     cwd_mask  = cfg_data[CWD_MASK_W-1:0];
                    CFG_PATH_MASK:    path_mask = cfg_data[PATH_MASK_W-1:0];
                    default:          ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: record_hash expected none, actual %h", $time, record_hash);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    hashes_checked++;
                    if (record_hash !== want)
                    begin
                        fail_count++;
                        $display("%0t: record_hash expected %h, actual %h",
                                 $time, want, record_hash);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                fold_audit_byte(char_byte, record_type, first_byte, last_byte, emit, hash_now);
                if (emit)
                    expected_hashes.push_back(hash_now);
            end
            pending_hashes = expected_hashes.size();
        end
    end

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench - top level for the audit record sieve hash
// Streams directed and random audit records through the block under several
// register settings and idling mixes; a checker beside the block predicts
// each hash and counts mismatches, and this module gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import arsh_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int BYTES_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = 4;
    // indexes past the last register: writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     char_byte;
    logic [TYPE_W-1:0]     record_type;
    logic                  first_byte;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [HASH_W-1:0]     record_hash;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_hashes;
    int hashes_checked;

    // stimulus bookkeeping
    logic [BYTE_W-1:0] text_q[$];
    logic [TYPE_W-1:0] sys_code;
    logic [TYPE_W-1:0] cwd_code;
    logic [TYPE_W-1:0] path_code;
    int                idle_pct;
    int                stall_pct;
    int                bytes_sent;
    int                records_sent;
    int                reg_writes;
    int                cycles;
    bit                hold_req;
    bit                hold_done;

    audit_record_sieve_hash_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_byte   (char_byte),
        .record_type (record_type),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .record_hash (record_hash),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    arsh_hash_checker hash_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_byte      (char_byte),
        .record_type    (record_type),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .record_hash    (record_hash),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_hashes (pending_hashes),
        .hashes_checked (hashes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a correct run finishes in a small fraction of this.
    initial
    begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d hashes still awaited", cycles, pending_hashes);
        $display("CHECKS FAILED");
        $finish;
    end

    // Hash receiver. Drop ready at random per the current stall rate; once asked,
    // hold it low for one long stretch so the output queue fills and the byte
    // channel backs up behind it.
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Any byte except a space; '=' only where asked for.
    function automatic logic [BYTE_W-1:0] text_byte(input bit allow_eq);
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255));
        while (b == BYTE_SPACE || (!allow_eq && b == BYTE_EQUALS));
        return b;
    endfunction

    // Offer one byte request; entered and left at a falling edge. Valid stays
    // high after acceptance so a back-to-back request never drops it.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic [TYPE_W-1:0] t,
                             input logic first, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        char_byte   = b;
        record_type = t;
        first_byte  = first;
        last_byte   = last;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        if (last)
            records_sent++;
        @(negedge clk);
    endtask

    // Send text_q as one record; the last byte carries the end mark.
    task automatic send_text(input logic [TYPE_W-1:0] t, input bit with_first);
        foreach (text_q[i])
            push_byte(text_q[i], t, with_first && i == 0, i == text_q.size() - 1);
    endtask

    // Build a well-formed record: prefix, space(s), then name=value fields.
    task automatic build_text(input int nf);
        text_q = {};
        repeat ($urandom_range(1, 3)) text_q.push_back(text_byte(1));
        text_q.push_back(BYTE_SPACE);
        repeat ($urandom_range(0, 2)) text_q.push_back(BYTE_SPACE);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
            begin
                text_q.push_back(BYTE_SPACE);
                // a doubled space becomes part of the next name
                if ($urandom_range(9) == 0)
                    text_q.push_back(BYTE_SPACE);
            end
            repeat ($urandom_range(0, 3)) text_q.push_back(text_byte(0));
            text_q.push_back(BYTE_EQUALS);
            repeat ($urandom_range(0, 3)) text_q.push_back(text_byte(1));
        end
    endtask

    // Stop offering bytes and wait for every expected hash, then a little more.
    task automatic wait_drain();
        in_valid = 1'b0;
        while (pending_hashes != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
        @(negedge clk);
    endtask

    // Write all six registers plus both spare indexes; call only while idle.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] st, input logic [CFG_DATA_W-1:0] ct,
                                  input logic [CFG_DATA_W-1:0] pt, input logic [CFG_DATA_W-1:0] sm,
                                  input logic [CFG_DATA_W-1:0] cm, input logic [CFG_DATA_W-1:0] pm);
        write_reg(CFG_SYSCALL_TYPE, st);
        write_reg(CFG_CWD_TYPE, ct);
        write_reg(CFG_PATH_TYPE, pt);
        write_reg(CFG_SYSCALL_MASK, sm);
        write_reg(CFG_CWD_MASK, cm);
        write_reg(CFG_PATH_MASK, pm);
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 33554431)));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 33554431)));
        cfg_valid = 1'b0;
        sys_code  = st[TYPE_W-1:0];
        cwd_code  = ct[TYPE_W-1:0];
        path_code = pt[TYPE_W-1:0];
    endtask

    initial
    begin
        logic [TYPE_W-1:0]     t;
        logic [CFG_DATA_W-1:0] shared;
        int                    kind;
        int                    nf;
        int                    cut;
        int                    target;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        char_byte    = '0;
        record_type  = '0;
        first_byte   = 1'b0;
        last_byte    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_req     = 1'b0;
        bytes_sent   = 0;
        records_sent = 0;
        reg_writes   = 0;
        sys_code     = SYSCALL_TYPE_RST;
        cwd_code     = CWD_TYPE_RST;
        path_code    = PATH_TYPE_RST;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed records, reset register values ----
        // One-byte records: both marks on the same request.
        push_byte(8'hFF, CWD_TYPE_RST, 1'b1, 1'b1);
        push_byte(8'h00, PATH_TYPE_RST, 1'b1, 1'b1);
        // Syscall record: extra spaces after the prefix, a dropped value, a kept
        // value, a doubled space folded into the next name, extreme bytes.
        text_q = '{8'h70, BYTE_SPACE, BYTE_SPACE, 8'h6B, BYTE_EQUALS, 8'h80, BYTE_SPACE,
                   BYTE_EQUALS, 8'hFF, BYTE_SPACE, BYTE_SPACE, BYTE_EQUALS, 8'h00};
        send_text(SYSCALL_TYPE_RST, 1'b1);
        // Unknown type: nothing but names is hashed.
        text_q = '{BYTE_SPACE, 8'h61, BYTE_EQUALS, 8'h7A};
        send_text(16'hFFFF, 1'b1);
        // Early end while still in the prefix.
        text_q = '{8'h71, 8'h72};
        send_text(16'h0000, 1'b1);
        // No first mark: carry on from the cleared state.
        text_q = '{BYTE_SPACE, 8'h62, BYTE_EQUALS, 8'h63};
        send_text(16'h0000, 1'b0);
        wait_drain();

        // ---- long receiver hold: fill the output queue, back up the input ----
        hold_req = 1'b1;
        repeat (24) push_byte(text_byte(1), sys_code, 1'b1, 1'b1);
        wait_drain();

        // ---- random records: defaults, random, all ones, equal codes/zeros ----
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1:
                begin
                    apply_settings(CFG_DATA_W'($urandom_range(0, 33554431)),
                                   CFG_DATA_W'($urandom_range(0, 33554431)),
                                   CFG_DATA_W'($urandom_range(0, 33554431)),
                                   CFG_DATA_W'($urandom_range(0, 33554431)),
                                   CFG_DATA_W'($urandom_range(0, 33554431)),
                                   CFG_DATA_W'($urandom_range(0, 33554431)));
                    idle_pct  = 67;
                    stall_pct = 0;
                end
                2:
                begin
                    // every code 0xFFFF after masking, so syscall must win
                    apply_settings('1, '1, '1, '1, '1, '1);
                    idle_pct  = 0;
                    stall_pct = 67;
                end
                3:
                begin
                    // cwd and path share a code, so cwd must win; syscall at zero
                    shared = CFG_DATA_W'($urandom_range(1, 65535));
                    apply_settings('0, shared, shared, '0, 25'd1, 25'hFF);
                    idle_pct  = 13;
                    stall_pct = 13;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase

            target = bytes_sent + BYTES_PER_PHASE;
            if (ph == 2)
            begin
                // 67 empty-named fields: field count saturates, no wrap to field 0
                text_q = '{8'h70, BYTE_SPACE};
                repeat (66)
                begin
                    text_q.push_back(BYTE_EQUALS);
                    text_q.push_back(BYTE_SPACE);
                end
                text_q.push_back(BYTE_EQUALS);
                text_q.push_back(8'hC3);
                send_text(sys_code, 1'b1);
            end

            while (bytes_sent < target)
            begin
                case ($urandom_range(0, 7))
                    2:       t = cwd_code;
                    3:       t = path_code;
                    4:       t = TYPE_W'($urandom_range(0, 65535));
                    5:       t = $urandom_range(1) ? '1 : '0;
                    default: t = sys_code;
                endcase
                nf   = ($urandom_range(9) == 0) ? $urandom_range(20, 28) : $urandom_range(0, 4);
                kind = $urandom_range(99);
                if (kind < 75)
                begin
                    build_text(nf);
                    send_text(t, 1'b1);
                end
                else if (kind < 85)
                begin
                    // cut short anywhere
                    build_text(nf);
                    cut    = $urandom_range(1, text_q.size());
                    text_q = text_q[0:cut-1];
                    send_text(t, 1'b1);
                end
                else if (kind < 92)
                begin
                    build_text(nf);
                    send_text(t, 1'b0);
                end
                else
                begin
                    // raw noise with random marks
                    repeat ($urandom_range(1, 4))
                        push_byte(BYTE_W'($urandom_range(255)), TYPE_W'($urandom_range(65535)),
                                  $urandom_range(3) == 0, $urandom_range(3) == 0);
                end
            end
            wait_drain();
        end

        repeat (10) @(negedge clk);
        $display("Streamed %0d bytes in %0d records under four register settings and idling mixes",
                 bytes_sent, records_sent);
        $display("Compared %0d hashes after %0d register writes and one long output hold",
                 hashes_checked, reg_writes);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
